// ===== hw/rtl/pmac_pkg.sv =====
// ----------------------------------------------------------------------------
// pmac_pkg
// Shared types and constants of the polynomial multiply-accumulate block.
// ----------------------------------------------------------------------------
package pmac_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 48;
   localparam int SUM_W    = 50;
   localparam int LOG2_W   = 3;

   localparam logic [LOG2_W-1:0] LOG2_LIMIT = 3'd5;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd5;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] a_sample;
      logic signed [SAMPLE_W-1:0] b_sample;
      logic signed [WORD_W-1:0]   acc_low;
      logic signed [WORD_W-1:0]   acc_high;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] product_word;
      logic                     last_word;
   } rsp_type;

   typedef enum logic {
      ST_LOAD,
      ST_COMPUTE
   } state_type;

   typedef struct packed {
      logic op_valid;
      logic head;
      logic last;
      logic high_half;
      logic end_run;
   } op_type;

endpackage

// ===== hw/rtl/pmac_store.sv =====
// ----------------------------------------------------------------------------
// pmac_store
// Sample memory (a and b packed) and accumulator memory (low and high words
// packed), one write port each, registered reads.
// ----------------------------------------------------------------------------
module pmac_store #(
   parameter int MAX_LENGTH = 32,
   localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
   input  logic                                    clock,
   input  logic                                    write_en,
   input  logic [ADDR_W-1:0]                       write_addr,
   input  pmac_pkg::req_type                       write_data,
   input  logic                                    read_en,
   input  logic [ADDR_W-1:0]                       addr_a,
   input  logic [ADDR_W-1:0]                       addr_b,
   input  logic [ADDR_W-1:0]                       addr_acc,
   output logic signed [pmac_pkg::SAMPLE_W-1:0]    a_rd,
   output logic signed [pmac_pkg::SAMPLE_W-1:0]    b_rd,
   output logic signed [pmac_pkg::WORD_W-1:0]      acc_low_rd,
   output logic signed [pmac_pkg::WORD_W-1:0]      acc_high_rd
);

   localparam int SW = pmac_pkg::SAMPLE_W;
   localparam int WW = pmac_pkg::WORD_W;

   logic [2*SW-1:0] sample_mem [MAX_LENGTH];
   logic [2*WW-1:0] acc_mem    [MAX_LENGTH];

   logic [SW-1:0]   a_rd_ff;
   logic [SW-1:0]   b_rd_ff;
   logic [2*WW-1:0] acc_rd_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         sample_mem[write_addr] <= {write_data.a_sample, write_data.b_sample};
         acc_mem[write_addr]    <= {write_data.acc_high, write_data.acc_low};
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         a_rd_ff   <= sample_mem[addr_a][2*SW-1:SW];
         b_rd_ff   <= sample_mem[addr_b][SW-1:0];
         acc_rd_ff <= acc_mem[addr_acc];
      end
   end

   assign a_rd        = a_rd_ff;
   assign b_rd        = b_rd_ff;
   assign acc_low_rd  = acc_rd_ff[WW-1:0];
   assign acc_high_rd = acc_rd_ff[2*WW-1:WW];

endmodule

// ===== hw/rtl/pmac_sequencer.sv =====
// ----------------------------------------------------------------------------
// pmac_sequencer
// Load counter, length register and the issue sequencer that walks every
// output word and its product terms through the memories.
// ----------------------------------------------------------------------------
module pmac_sequencer #(
   parameter int MAX_LENGTH = 32,
   localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [pmac_pkg::LOG2_W-1:0]   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          advance,
   output logic                          load_we,
   output logic [ADDR_W-1:0]             load_addr,
   output pmac_pkg::op_type              issue,
   output logic [ADDR_W-1:0]             addr_a,
   output logic [ADDR_W-1:0]             addr_b,
   output logic [ADDR_W-1:0]             addr_acc
);

   localparam int N_W = $clog2(2 * MAX_LENGTH) + 1;
   localparam logic [pmac_pkg::LOG2_W-1:0] MAX_LOG2 = pmac_pkg::LOG2_W'($clog2(MAX_LENGTH));
   localparam logic [N_W-1:0] MAX_LEN = N_W'(MAX_LENGTH);

   pmac_pkg::state_type          state_ff, state_in;
   logic [pmac_pkg::LOG2_W-1:0]  length_log2_ff, length_log2_in;
   logic [N_W-1:0]               load_count_ff, load_count_in;
   logic [N_W-1:0]               n_ff, n_in;
   logic [N_W-1:0]               i_ff, i_in;
   logic                         head_ff, head_in;

   logic [pmac_pkg::LOG2_W-1:0]  lg;
   logic [N_W-1:0]               len;
   logic [N_W-1:0]               last_n;
   logic [N_W-1:0]               k;
   logic                         accept;
   logic                         load_done;
   logic                         n_low;
   logic [N_W-1:0]               acc_idx;
   logic [N_W-1:0]               i_first;
   logic [N_W-1:0]               i_end;
   logic [N_W-1:0]               j;
   logic                         is_final;
   logic                         term_last;
   logic                         step;

   always_comb begin
      lg        = (length_log2_ff > pmac_pkg::LOG2_LIMIT) ? pmac_pkg::LOG2_LIMIT
                                                          : length_log2_ff;
      len       = (lg >= MAX_LOG2) ? MAX_LEN : (N_W'(1) << lg);
      last_n    = (len << 1) - N_W'(1);
      k         = (load_count_ff >= len) ? '0 : load_count_ff;
      accept    = req_valid && req_ready;
      load_done = (k + N_W'(1)) == len;
      n_low     = n_ff < len;
      acc_idx   = n_low ? n_ff : n_ff - len;
      i_first   = n_low ? '0 : n_ff - len + N_W'(1);
      i_end     = n_low ? n_ff : len - N_W'(1);
      j         = n_ff - i_ff;
      is_final  = n_ff == last_n;
      term_last = i_ff == i_end;
      step      = advance && (state_ff == pmac_pkg::ST_COMPUTE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmac_pkg::ST_LOAD: begin
            if (accept && load_done) begin
               state_in = pmac_pkg::ST_COMPUTE;
            end
         end
         pmac_pkg::ST_COMPUTE: begin
            if (step && head_ff && is_final) begin
               state_in = pmac_pkg::ST_LOAD;
            end
         end
         default: state_in = pmac_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      length_log2_in = length_log2_ff;
      load_count_in  = load_count_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      head_in        = head_ff;
      priority if (csr_valid) begin
         length_log2_in = csr_data;
         load_count_in  = '0;
      end else if (accept) begin
         load_count_in = load_done ? '0 : k + N_W'(1);
      end else begin
         load_count_in = load_count_ff;
      end
      if (accept && load_done) begin
         n_in    = '0;
         head_in = 1'b1;
      end
      if (step) begin
         if (head_ff) begin
            if (!is_final) begin
               head_in = 1'b0;
               i_in    = i_first;
            end
         end else if (term_last) begin
            n_in    = n_ff + N_W'(1);
            head_in = 1'b1;
         end else begin
            i_in = i_ff + N_W'(1);
         end
      end
   end

   always_comb begin
      req_ready       = state_ff == pmac_pkg::ST_LOAD;
      load_we         = accept;
      load_addr       = k[ADDR_W-1:0];
      issue.op_valid  = step;
      issue.head      = head_ff;
      issue.last      = head_ff ? is_final : term_last;
      issue.high_half = !n_low;
      issue.end_run   = is_final;
      addr_a          = i_ff[ADDR_W-1:0];
      addr_b          = j[ADDR_W-1:0];
      addr_acc        = acc_idx[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pmac_pkg::ST_LOAD;
         length_log2_ff <= pmac_pkg::LOG2_RESET;
         load_count_ff  <= '0;
         n_ff           <= '0;
         i_ff           <= '0;
         head_ff        <= 1'b1;
      end else begin
         state_ff       <= state_in;
         length_log2_ff <= length_log2_in;
         load_count_ff  <= load_count_in;
         n_ff           <= n_in;
         i_ff           <= i_in;
         head_ff        <= head_in;
      end
   end

endmodule

// ===== hw/rtl/pmac_datapath.sv =====
// ----------------------------------------------------------------------------
// pmac_datapath
// Multiply, accumulate and saturate pipeline with the result register.
// ----------------------------------------------------------------------------
module pmac_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pmac_pkg::op_type                      issue,
   input  logic signed [pmac_pkg::SAMPLE_W-1:0]  a_rd,
   input  logic signed [pmac_pkg::SAMPLE_W-1:0]  b_rd,
   input  logic signed [pmac_pkg::WORD_W-1:0]    acc_low_rd,
   input  logic signed [pmac_pkg::WORD_W-1:0]    acc_high_rd,
   output logic                                  advance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pmac_pkg::rsp_type                     rsp_payload
);

   localparam int WW = pmac_pkg::WORD_W;
   localparam int SW = pmac_pkg::SUM_W;
   localparam int PW = 2 * pmac_pkg::SAMPLE_W;

   pmac_pkg::op_type       s1_op_ff;
   pmac_pkg::op_type       s2_op_ff;
   logic signed [PW-1:0]   product_ff, product_in;
   logic signed [WW-1:0]   acc_word_ff, acc_word_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic                   done_ff, done_in;
   logic                   end_ff, end_in;
   logic                   rsp_valid_ff;
   pmac_pkg::rsp_type      rsp_payload_ff, rsp_payload_in;
   logic [SW-WW:0]         top_bits;

   always_comb begin
      advance     = !rsp_valid_ff || rsp_ready;
      product_in  = a_rd * b_rd;
      acc_word_in = s1_op_ff.high_half ? acc_high_rd : acc_low_rd;
      sum_in      = sum_ff;
      if (s2_op_ff.op_valid) begin
         sum_in = s2_op_ff.head
                ? {{(SW-WW){acc_word_ff[WW-1]}}, acc_word_ff}
                : sum_ff + {{(SW-PW){product_ff[PW-1]}}, product_ff};
      end
      done_in  = s2_op_ff.op_valid && s2_op_ff.last;
      end_in   = s2_op_ff.end_run;
      top_bits = sum_ff[SW-1:WW-1];
      priority if ((&top_bits) || !(|top_bits)) begin
         rsp_payload_in.product_word = sum_ff[WW-1:0];
      end else if (sum_ff[SW-1]) begin
         rsp_payload_in.product_word = pmac_pkg::WORD_MIN;
      end else begin
         rsp_payload_in.product_word = pmac_pkg::WORD_MAX;
      end
      rsp_payload_in.last_word = end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff     <= '0;
         s2_op_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_op_ff     <= issue;
         s2_op_ff     <= s1_op_ff;
         done_ff      <= done_in;
         rsp_valid_ff <= done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff     <= product_in;
         acc_word_ff    <= acc_word_in;
         sum_ff         <= sum_in;
         end_ff         <= end_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hw/rtl/polynomial_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_accumulate
// Full linear convolution of two length-L vectors added onto an accumulator.
//
// req channel: one transaction per element k, carrying a[k], b[k] and the
// prior accumulator words k and k+L. rsp channel: after element L-1, the 2L
// saturated words in index order, last_word set on word 2L-1. csr channel:
// writes length_log2 (L = 2^min(length_log2, 5), capped at MAX_LENGTH) and
// restarts loading at element 0; write it only while the block is idle.
// Each element is written to memory in the cycle it is accepted. The result
// run is produced by one multiply-accumulate unit fed from the sample memory:
// each word issues its accumulator read followed by one operation per product
// term. After element L-1 is accepted, each operation passes the memory
// read and s1 registers, the s2 registers and the sum register, and a
// finished word leaves through the response register. req_ready is low
// while the run is issued; the next load starts while the last words still
// drain. A stalled rsp side freezes the whole pipeline; nothing is dropped.
// Reset sets length_log2 to 5 and clears the load count; memory contents
// are not cleared.
// ----------------------------------------------------------------------------
module polynomial_multiply_accumulate #(
   parameter int MAX_LENGTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pmac_pkg::LOG2_W-1:0]   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pmac_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pmac_pkg::rsp_type             rsp_payload
);

   localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   logic                                  advance;
   logic                                  load_we;
   logic [ADDR_W-1:0]                     load_addr;
   pmac_pkg::op_type                      issue;
   logic [ADDR_W-1:0]                     addr_a;
   logic [ADDR_W-1:0]                     addr_b;
   logic [ADDR_W-1:0]                     addr_acc;
   logic signed [pmac_pkg::SAMPLE_W-1:0]  a_rd;
   logic signed [pmac_pkg::SAMPLE_W-1:0]  b_rd;
   logic signed [pmac_pkg::WORD_W-1:0]    acc_low_rd;
   logic signed [pmac_pkg::WORD_W-1:0]    acc_high_rd;

   assign csr_ready = 1'b1;

   pmac_sequencer #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .advance   (advance),
      .load_we   (load_we),
      .load_addr (load_addr),
      .issue     (issue),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .addr_acc  (addr_acc)
   );

   pmac_store #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_store (
      .clock       (clock),
      .write_en    (load_we),
      .write_addr  (load_addr),
      .write_data  (req_payload),
      .read_en     (advance),
      .addr_a      (addr_a),
      .addr_b      (addr_b),
      .addr_acc    (addr_acc),
      .a_rd        (a_rd),
      .b_rd        (b_rd),
      .acc_low_rd  (acc_low_rd),
      .acc_high_rd (acc_high_rd)
   );

   pmac_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .a_rd        (a_rd),
      .b_rd        (b_rd),
      .acc_low_rd  (acc_low_rd),
      .acc_high_rd (acc_high_rd),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
